// ----- design/bam_pkg.sv -----
`timescale 1ns / 1ps

package bam_pkg;

    localparam int MAX_BLOCKS = 65536;
    localparam int MAP_WORDS  = (MAX_BLOCKS + 31) / 32;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int SECT_W     = 17;
    localparam int OFF_W      = WORD_AW + 5;
    localparam int PAGE_WORDS = 127;
    localparam int PAGES      = 17;
    localparam int PAGE_W     = 5;
    localparam int MAX_ALLOC  = 8;
    localparam int KW         = $clog2(MAX_ALLOC);
    localparam int PAGE_SHIFT = 20;
    localparam int PAGE_RECIP = ((1 << PAGE_SHIFT) + PAGE_WORDS - 1) / PAGE_WORDS;
    localparam int PROD_W     = WORD_AW + 14;

    localparam logic [SECT_W-1:0] TOP_CAP = SECT_W'(MAX_BLOCKS + 1);

    localparam logic [3:0] MODE_FREE   = 4'd0;
    localparam logic [3:0] MODE_USED   = 4'd1;
    localparam logic [3:0] MODE_TEST   = 4'd2;
    localparam logic [3:0] MODE_ALLOC  = 4'd3;
    localparam logic [3:0] MODE_COUNT  = 4'd4;
    localparam logic [3:0] MODE_FORMAT = 4'd5;
    localparam logic [3:0] MODE_LOAD   = 4'd6;
    localparam logic [3:0] MODE_READ   = 4'd7;
    localparam logic [3:0] MODE_DIRTY  = 4'd8;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [3:0]  mode;
        logic [16:0] sector;
        logic [3:0]  alloc_count;
        logic [4:0]  page_index;
        logic [10:0] word_index;
        logic [31:0] word_data;
    } in_item_t;

    typedef struct packed {
        logic [16:0] sector_out;
        logic        is_free;
        logic [16:0] free_count;
        logic [31:0] word_out;
        logic        page_dirty;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic              bad;
        logic [3:0]        mode;
        logic [OFF_W-1:0]  off;
        logic [3:0]        want;
        logic [PAGE_W-1:0] page;
        logic [WORD_AW-1:0] widx;
        logic [31:0]       data;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [SECT_W-1:0] top;
        logic [OFF_W-1:0]  off;
    } limits_t;

    function automatic limits_t top_limit(input logic [SECT_W-1:0] last);
        limits_t l;
        logic [SECT_W-1:0] d;
        l.top = (last > TOP_CAP) ? TOP_CAP : last;
        l.ok  = (l.top >= SECT_W'(2));
        d     = l.top - SECT_W'(2);
        l.off = d[OFF_W-1:0];
        return l;
    endfunction

    function automatic logic [PAGE_W-1:0] page_of(input logic [WORD_AW-1:0] w);
        logic [PROD_W-1:0] p;
        p = PROD_W'(w) * PROD_W'(PAGE_RECIP);
        return p[PAGE_SHIFT +: PAGE_W];
    endfunction

    function automatic logic [5:0] popcount(input logic [31:0] v);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < 32; i++)
        begin
            c = c + {5'd0, v[i]};
        end
        return c;
    endfunction

    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] b;
        b = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

endpackage

// ----- design/block_allocation_bitmap.sv -----
`timescale 1ns / 1ps

// Free-block bitmap, one bit per sector (set = free), held in a 2048 x 32 map
// memory. After reset the block clears every map word with full held high;
// configuration writes are still taken. A front stage checks each item and
// queues it; a back sequencer executes one item at a time on the single map
// memory. Free, used, test and read word items read their map word and then
// act on it; load word, take dirty and rejected items need no map read; count
// and format read each map word up to the last sector; an allocation scans
// map words from the root for free sectors, then reads each found sector's
// word to mark it used, one item out per sector.
module block_allocation_bitmap (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bam_pkg::in_item_t  req,
    output logic               empty,
    input  logic               pop,
    output bam_pkg::out_item_t rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bam_pkg::*;

    logic [16:0] root_reg, root_next;
    logic [16:0] last_reg, last_next;
    logic        cfg_wr;
    logic        hold;
    logic        cmd_empty;
    logic        cmd_pop;
    cmd_t        cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {15'd0, last_reg} : {15'd0, root_reg};

    always_comb
    begin
        root_next = root_reg;
        last_next = last_reg;
        if (cfg_wr)
        begin
            if (paddr[2])
            begin
                last_next = pwdata[16:0];
            end
            else
            begin
                root_next = pwdata[16:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= 17'd880;
            last_reg <= 17'd1759;
        end
        else
        begin
            root_reg <= root_next;
            last_reg <= last_next;
        end
    end

    bam_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .root      (root_reg),
        .last      (last_reg),
        .hold      (hold),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    bam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .root      (root_reg),
        .last      (last_reg),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .clearing  (hold),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

// ----- design/bam_ram.sv -----
`timescale 1ns / 1ps

module bam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/bam_front.sv -----
`timescale 1ns / 1ps

module bam_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bam_pkg::in_item_t  req,
    input  logic [16:0]        root,
    input  logic [16:0]        last,
    input  logic               hold,
    output logic               cmd_empty,
    input  logic               cmd_pop,
    output bam_pkg::cmd_t      cmd
);
    import bam_pkg::*;

    limits_t    lim;
    cmd_t       cls;
    logic       sect_ok;
    logic       root_ok;
    logic [16:0] s_off;
    logic       accept;
    logic       take;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        lim     = top_limit(last);
        sect_ok = lim.ok && (req.sector >= 17'd2) && (req.sector <= lim.top);
        root_ok = lim.ok && (root >= 17'd2) && (root <= lim.top);
        s_off   = req.sector - 17'd2;
        cls.mode = req.mode;
        cls.off  = s_off[OFF_W-1:0];
        cls.want = req.alloc_count;
        cls.page = req.page_index;
        cls.widx = req.word_index;
        cls.data = req.word_data;
        case (req.mode)
            MODE_FREE, MODE_USED, MODE_TEST:
                cls.bad = !sect_ok;
            MODE_ALLOC:
                cls.bad = (req.alloc_count == 4'd0) || (req.alloc_count > 4'(MAX_ALLOC))
                          || !root_ok;
            MODE_COUNT, MODE_FORMAT:
                cls.bad = 1'b0;
            MODE_LOAD, MODE_READ:
                cls.bad = ({1'b0, req.word_index} >= 12'(MAP_WORDS));
            MODE_DIRTY:
                cls.bad = (req.page_index >= 5'(PAGES));
            default:
                cls.bad = 1'b1;
        endcase
    end

    assign full      = hold || (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_empty = (cnt_reg == 2'd0);
    assign take      = cmd_pop && !cmd_empty;
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ accept;
        rp_next  = rp_reg ^ take;
        cnt_next = cnt_reg + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

// ----- design/bam_back.sv -----
`timescale 1ns / 1ps

module bam_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [16:0]        root,
    input  logic [16:0]        last,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    input  bam_pkg::cmd_t      cmd,
    output logic               clearing,
    output logic               empty,
    input  logic               pop,
    output bam_pkg::out_item_t rsp
);
    import bam_pkg::*;

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_EX     = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;
    localparam logic [2:0] S_CMT_RD = 3'd5;
    localparam logic [2:0] S_CMT_EX = 3'd6;

    logic [2:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [WORD_AW-1:0]  wp_reg, wp_next;
    logic                phase_reg, phase_next;
    logic [3:0]          got_reg, got_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [31:0]         mask_reg, mask_next;
    logic [16:0]         cnt_reg, cnt_next;
    logic [OFF_W-1:0]    pend_reg [MAX_ALLOC];
    logic [OFF_W-1:0]    pend_next [MAX_ALLOC];
    out_item_t           res_reg, res_next;
    logic [PAGES-1:0]    dirty_reg, dirty_next;
    logic [WORD_AW-1:0]  clr_reg, clr_next;

    logic                wr_en;
    logic [WORD_AW-1:0]  wr_addr;
    logic [31:0]         wr_data;
    logic                rd_en;
    logic [WORD_AW-1:0]  rd_addr;
    logic [31:0]         rd_data;

    out_item_t           rq_reg [2];
    logic                rq_wp_reg, rq_rp_reg;
    logic [1:0]          rq_cnt_reg;
    logic                rq_push;
    out_item_t           rq_in;
    logic                rq_take;
    logic                rq_space;

    limits_t             lim;
    logic [OFF_W-1:0]    r_off;
    logic [OFF_W-1:0]    r_m1;
    logic [WORD_AW-1:0]  tw;
    logic [WORD_AW-1:0]  rw;
    logic [WORD_AW-1:0]  ew;
    logic [31:0]         hi_mask;
    logic [31:0]         calc_mask;
    logic [16:0]         r_wide;

    bam_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        lim     = top_limit(last);
        r_wide  = root - 17'd2;
        r_off   = r_wide[OFF_W-1:0];
        r_m1    = r_off - OFF_W'(1);
        tw      = lim.off[OFF_W-1:5];
        rw      = r_off[OFF_W-1:5];
        ew      = r_m1[OFF_W-1:5];
        hi_mask = 32'hFFFF_FFFF >> (5'd31 - lim.off[4:0]);
        calc_mask = 32'hFFFF_FFFF;
        if (cmd_reg.mode == MODE_ALLOC)
        begin
            if (!phase_reg)
            begin
                if (wp_reg == rw)
                begin
                    calc_mask = calc_mask & (32'hFFFF_FFFF << r_off[4:0]);
                end
                if (wp_reg == tw)
                begin
                    calc_mask = calc_mask & hi_mask;
                end
            end
            else if (wp_reg == ew)
            begin
                calc_mask = 32'hFFFF_FFFF >> (5'd31 - r_m1[4:0]);
            end
        end
        else if (wp_reg == tw)
        begin
            calc_mask = hi_mask;
        end
    end

    assign rq_space = (rq_cnt_reg != 2'd2);
    assign clearing = (state_reg == S_CLR);

    always_comb
    begin
        logic [31:0]        avail;
        logic [4:0]         bit_sel;
        logic [5:0]         pc;
        logic [PAGE_W-1:0]  pg;
        logic [OFF_W-1:0]   poff;
        logic               done_cmt;

        state_next = state_reg;
        cmd_next   = cmd_reg;
        wp_next    = wp_reg;
        phase_next = phase_reg;
        got_next   = got_reg;
        k_next     = k_reg;
        mask_next  = mask_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        dirty_next = dirty_reg;
        clr_next   = clr_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = wp_reg;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = wp_reg;
        rq_push    = 1'b0;
        rq_in      = res_reg;
        avail      = rd_data & mask_reg;
        bit_sel    = lowest_set(avail);
        pc         = popcount(avail);
        pg         = page_of(wp_reg);
        poff       = pend_reg[k_reg];
        done_cmt   = ({1'b0, k_reg} == (cmd_reg.want - 4'd1));

        unique case (state_reg)
            S_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + WORD_AW'(1);
                if (clr_reg == WORD_AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    res_next   = '0;
                    res_next.last = 1'b1;
                    phase_next = 1'b0;
                    got_next   = '0;
                    cnt_next   = '0;
                    wp_next    = cmd.off[OFF_W-1:5];
                    state_next = S_RD;
                    if (cmd.bad)
                    begin
                        res_next.status = STATUS_RANGE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        case (cmd.mode)
                            MODE_LOAD:
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = cmd.widx;
                                wr_data    = cmd.data;
                                state_next = S_RESP;
                            end
                            MODE_READ:
                                wp_next = cmd.widx;
                            MODE_DIRTY:
                            begin
                                res_next.page_dirty  = dirty_reg[cmd.page];
                                dirty_next[cmd.page] = 1'b0;
                                state_next           = S_RESP;
                            end
                            MODE_COUNT, MODE_FORMAT:
                            begin
                                wp_next = '0;
                                if (!lim.ok)
                                begin
                                    state_next = S_RESP;
                                end
                            end
                            MODE_ALLOC:
                                wp_next = rw;
                            default:
                                wp_next = cmd.off[OFF_W-1:5];
                        endcase
                    end
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                mask_next  = calc_mask;
                state_next = S_EX;
            end
            S_EX:
            begin
                state_next = S_RESP;
                case (cmd_reg.mode)
                    MODE_FREE, MODE_USED:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                        wr_data[cmd_reg.off[4:0]] = (cmd_reg.mode == MODE_FREE);
                        if (pg < PAGE_W'(PAGES))
                        begin
                            dirty_next[pg] = 1'b1;
                        end
                    end
                    MODE_TEST:
                        res_next.is_free = rd_data[cmd_reg.off[4:0]];
                    MODE_READ:
                        res_next.word_out = rd_data;
                    MODE_COUNT:
                    begin
                        cnt_next = cnt_reg + {11'd0, pc};
                        if (wp_reg == tw)
                        begin
                            res_next.free_count = cnt_reg + {11'd0, pc};
                        end
                        else
                        begin
                            wp_next    = wp_reg + WORD_AW'(1);
                            state_next = S_RD;
                        end
                    end
                    MODE_FORMAT:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data | mask_reg;
                        for (int p = 0; p < PAGES; p++)
                        begin
                            if (PAGE_W'(p) <= pg)
                            begin
                                dirty_next[p] = 1'b1;
                            end
                        end
                        if (wp_reg != tw)
                        begin
                            wp_next    = wp_reg + WORD_AW'(1);
                            state_next = S_RD;
                        end
                    end
                    MODE_ALLOC:
                    begin
                        if (got_reg == cmd_reg.want)
                        begin
                            k_next     = '0;
                            state_next = S_CMT_RD;
                        end
                        else if (avail != 32'd0)
                        begin
                            pend_next[got_reg[KW-1:0]] = {wp_reg, bit_sel};
                            got_next   = got_reg + 4'd1;
                            mask_next  = mask_reg & ~(32'd1 << bit_sel);
                            state_next = S_EX;
                        end
                        else if (!phase_reg && (wp_reg == tw))
                        begin
                            if (r_off == '0)
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                phase_next = 1'b1;
                                wp_next    = '0;
                                state_next = S_RD;
                            end
                        end
                        else if (phase_reg && (wp_reg == ew))
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            wp_next    = wp_reg + WORD_AW'(1);
                            state_next = S_RD;
                        end
                    end
                    default:
                        res_next.status = STATUS_RANGE;
                endcase
            end
            S_RESP:
            begin
                if (rq_space)
                begin
                    rq_push    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CMT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = poff[OFF_W-1:5];
                wp_next    = poff[OFF_W-1:5];
                state_next = S_CMT_EX;
            end
            S_CMT_EX:
            begin
                if (rq_space)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wp_reg;
                    wr_data = rd_data & ~(32'd1 << poff[4:0]);
                    if (pg < PAGE_W'(PAGES))
                    begin
                        dirty_next[pg] = 1'b1;
                    end
                    rq_push          = 1'b1;
                    rq_in            = '0;
                    rq_in.sector_out = {1'b0, poff} + 17'd2;
                    rq_in.status     = STATUS_OK;
                    rq_in.last       = done_cmt;
                    if (done_cmt)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_CMT_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            dirty_reg <= '0;
            phase_reg <= 1'b0;
            got_reg   <= '0;
            k_reg     <= '0;
            wp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            dirty_reg <= dirty_next;
            phase_reg <= phase_next;
            got_reg   <= got_next;
            k_reg     <= k_next;
            wp_reg    <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        mask_reg <= mask_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    // result queue
    assign empty   = (rq_cnt_reg == 2'd0);
    assign rq_take = pop && !empty;
    assign rsp     = rq_reg[rq_rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wp_reg  <= 1'b0;
            rq_rp_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            rq_wp_reg  <= rq_wp_reg ^ rq_push;
            rq_rp_reg  <= rq_rp_reg ^ rq_take;
            rq_cnt_reg <= rq_cnt_reg + {1'b0, rq_push} - {1'b0, rq_take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_wp_reg] <= rq_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !cmd_pop)
        else $error("command taken during map clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rq_push && !rq_in.last) |-> (state_reg == S_CMT_EX))
        else $error("non-final item outside allocation commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EX && cmd_reg.mode == MODE_ALLOC) |-> (got_reg <= cmd_reg.want))
        else $error("allocation collected too many sectors");

    assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> rq_space)
        else $error("result queue overflow");

endmodule
